// File: rtl/assert_macros.svh
// Assertion macros shared by the modular arithmetic unit RTL.
// Each macro expands to a concurrent assertion in simulation and to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/mau_pkg.sv
`timescale 1ns / 1ps
// Package for the modular arithmetic unit: widths, command codes and the cell payload type.
// No dependencies.
package mau_pkg;
	localparam int WIDTH = 64;
	localparam int DEPTH = 2 * WIDTH + 2;
	localparam int LVL_W = $clog2(DEPTH + 1);

	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_SUB = 2'd1;
	localparam logic [1:0] CMD_MUL = 2'd2;

	// Item state handed from cell to cell.
	typedef struct packed {
		logic             vld;
		logic [1:0]       cmd;
		logic [WIDTH-1:0] m;
		logic [WIDTH-1:0] a;
		logic [WIDTH-1:0] b;
		logic [WIDTH-1:0] acc;
	} cell_t;

	// Conditional subtract: x < 2m in, x mod m out, done at WIDTH+1 bits.
	function automatic logic [WIDTH-1:0] red1(input logic [WIDTH:0] x,
		input logic [WIDTH-1:0] m);
		logic [WIDTH:0] d;
		d = x - {1'b0, m};
		red1 = (x >= {1'b0, m}) ? d[WIDTH-1:0] : x[WIDTH-1:0];
	endfunction
endpackage

// File: rtl/mau_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interface with a generic payload.
// Depends on no package.
interface mau_stream_if #(parameter int PW = 8);
	logic          valid;
	logic          ready;
	logic [PW-1:0] payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/modular_add_sub_mul_unit.sv
`timescale 1ns / 1ps
// Modular add/subtract/multiply unit: two rows of WIDTH operand-reduction cells side by side,
// a row of WIDTH multiply cells and a final cell, 2*WIDTH+1 register stages deep.
// Throughput: one item per cycle; the whole chain stops only while a result waits untaken.
// Each item carries its modulus copy, so a modulus write affects later items only.
// Reset (arst_n low) empties the chain and sets the modulus to 1.
// Depends on mau_pkg, mau_stream_if, mau_cell, mau_final and assert_macros.svh.
`include "assert_macros.svh"
module modular_add_sub_mul_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [63:0]               cfg_wdata,
	mau_stream_if.sink                in_ch,
	mau_stream_if.source              out_ch
);
	logic [mau_pkg::WIDTH-1:0] modulus_q;
	mau_pkg::cell_t            link [0:mau_pkg::WIDTH];
	logic                      en;
	logic                      fvld;
	logic [mau_pkg::WIDTH-1:0] fres;
	logic [1:0]                cmd_in;
	logic [mau_pkg::WIDTH-1:0] a_in;
	logic [mau_pkg::WIDTH-1:0] b_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= mau_pkg::WIDTH'(1);
		end else if (cfg_we && (cfg_wdata[mau_pkg::WIDTH-1:0] != '0)) begin
			modulus_q <= cfg_wdata[mau_pkg::WIDTH-1:0];
		end
	end

	// The chain moves whenever the output register is free or being emptied.
	assign en = !fvld || out_ch.ready;
	assign in_ch.ready = en;

	assign cmd_in = in_ch.payload[2*64+1:2*64];
	assign a_in = in_ch.payload[2*64-1:64];
	assign b_in = in_ch.payload[63:0];

	// The first row reduces a into acc while a shifts out.
	always_comb begin
		link[0].vld = in_ch.valid;
		link[0].cmd = cmd_in;
		link[0].m = modulus_q;
		link[0].a = a_in;
		link[0].b = '0;
		link[0].acc = '0;
	end

	mau_pkg::cell_t mid;
	mau_pkg::cell_t bred [0:mau_pkg::WIDTH];
	logic [mau_pkg::WIDTH-1:0] bsh_q [1:mau_pkg::WIDTH];

	genvar i;
	generate
		for (i = 0; i < mau_pkg::WIDTH; i++) begin : g_red
			mau_cell u_cell (
				.clk(clk), .arst_n(arst_n), .en(en),
				.lvl(mau_pkg::LVL_W'(i)), .din(link[i]), .dout(link[i+1])
			);
		end
	endgenerate

	// Operand b travels beside the a reduction in its own cell row.
	always_comb begin
		bred[0].vld = in_ch.valid;
		bred[0].cmd = cmd_in;
		bred[0].m = modulus_q;
		bred[0].a = b_in;
		bred[0].b = '0;
		bred[0].acc = '0;
	end
	generate
		for (i = 0; i < mau_pkg::WIDTH; i++) begin : g_redb
			mau_cell u_cellb (
				.clk(clk), .arst_n(arst_n), .en(en),
				.lvl(mau_pkg::LVL_W'(i)), .din(bred[i]), .dout(bred[i+1])
			);
		end
	endgenerate

	// Hand over: a = reduced a, b = reduced b, accumulator cleared.
	always_comb begin
		mid = link[mau_pkg::WIDTH];
		mid.a = link[mau_pkg::WIDTH].acc;
		mid.b = bred[mau_pkg::WIDTH].acc;
		mid.acc = '0;
	end

	mau_pkg::cell_t mlink [0:mau_pkg::WIDTH];
	assign mlink[0] = mid;
	generate
		for (i = 0; i < mau_pkg::WIDTH; i++) begin : g_mul
			mau_cell u_cellm (
				.clk(clk), .arst_n(arst_n), .en(en),
				.lvl(mau_pkg::LVL_W'(mau_pkg::WIDTH + i)), .din(mlink[i]),
				.dout(mlink[i+1])
			);
		end
	endgenerate

	// The multiply row shifts b away, so a copy of reduced b rides beside it.
	always_ff @(posedge clk) begin
		if (en) begin
			bsh_q[1] <= bred[mau_pkg::WIDTH].acc;
			for (int j = 2; j <= mau_pkg::WIDTH; j++) begin
				bsh_q[j] <= bsh_q[j-1];
			end
		end
	end

	mau_pkg::cell_t fin;
	always_comb begin
		fin = mlink[mau_pkg::WIDTH];
		fin.b = bsh_q[mau_pkg::WIDTH];
	end

	mau_final u_final (
		.clk(clk), .arst_n(arst_n), .en(en), .din(fin), .vld(fvld), .res(fres)
	);

	assign out_ch.valid = fvld;
	assign out_ch.payload = fres;

	`ASSERT_IMPL(a_ready_when_empty, !fvld, in_ch.ready)
	`ASSERT_NEXT(a_mod_nonzero, 1'b1, modulus_q != '0)
	`ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(fres))
endmodule

// File: rtl/mau_cell.sv
`timescale 1ns / 1ps
// One cell of the reduction chain: a reduce or shift-add step chosen by its level.
// Depends on mau_pkg.
module mau_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic [mau_pkg::LVL_W-1:0] lvl,
	input  mau_pkg::cell_t         din,
	output mau_pkg::cell_t         dout
);
	mau_pkg::cell_t nxt;
	mau_pkg::cell_t cell_q;
	logic vld_q;
	logic [mau_pkg::WIDTH:0] sh;
	logic [mau_pkg::WIDTH-1:0] dbl;
	logic bitv;

	// Levels 0..WIDTH-1 reduce a one bit at a time (MSB first) into acc;
	// levels WIDTH..2*WIDTH-1 run one multiply step each.
	always_comb begin
		nxt = din;
		bitv = 1'b0;
		sh = '0;
		dbl = '0;
		if (lvl < mau_pkg::LVL_W'(mau_pkg::WIDTH)) begin
			// The operand remainder builds up as r = 2r + bit, reduced once per step.
			sh = {din.acc, din.a[mau_pkg::WIDTH-1]};
			nxt.acc = mau_pkg::red1(sh, din.m);
			nxt.a = {din.a[mau_pkg::WIDTH-2:0], 1'b0};
		end else if (lvl < mau_pkg::LVL_W'(2 * mau_pkg::WIDTH)) begin
			bitv = din.b[mau_pkg::WIDTH-1];
			dbl = mau_pkg::red1({din.acc, 1'b0}, din.m);
			nxt.acc = bitv ? mau_pkg::red1({1'b0, dbl} + {1'b0, din.a}, din.m) : dbl;
			nxt.b = {din.b[mau_pkg::WIDTH-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= nxt.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= nxt;
		end
	end

	always_comb begin
		dout = cell_q;
		dout.vld = vld_q;
	end
endmodule

// File: rtl/mau_final.sv
`timescale 1ns / 1ps
// Final cell: applies add, subtract or the multiply result, and holds the output register.
// Depends on mau_pkg.
module mau_final (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  mau_pkg::cell_t                din,
	output logic                          vld,
	output logic [mau_pkg::WIDTH-1:0]     res
);
	logic [mau_pkg::WIDTH:0] s;
	logic [mau_pkg::WIDTH-1:0] r;
	logic vld_q;
	logic [mau_pkg::WIDTH-1:0] res_q;

	always_comb begin
		s = '0;
		case (din.cmd)
			mau_pkg::CMD_ADD: begin
				s = {1'b0, din.a} + {1'b0, din.b};
				r = mau_pkg::red1(s, din.m);
			end
			mau_pkg::CMD_SUB: begin
				s = {1'b0, din.a} - {1'b0, din.b};
				r = (din.a >= din.b) ? s[mau_pkg::WIDTH-1:0] :
					s[mau_pkg::WIDTH-1:0] + din.m;
			end
			mau_pkg::CMD_MUL: r = din.acc;
			default: r = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= r;
		end
	end

	assign vld = vld_q;
	assign res = res_q;
endmodule
